FILE: hdl/aprns_pkg.sv
package aprns_pkg;

    // Field widths
    localparam int COORD_W    = 24;
    localparam int SIZE_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int ID_W       = 5;

    // Shared multiplier: unsigned operands, full-width product
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;

    // Squared distance: three squares of 24-bit magnitudes
    localparam int D2_W       = 50;
    localparam int SQ_W       = 2 * COORD_W;

    // Distance scaling: Q12.12 squared vs (Q4.12 * Q4.12) squared
    localparam int SH_OWN     = 24;
    localparam int SH_MEAN    = 26;
    localparam int CMP_W      = D2_W + SH_MEAN;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_SELF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_THREE_DIMS = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    typedef struct packed {
        logic [ID_W-1:0] point_id;
        logic [ID_W-1:0] other_id;
        logic            new_reaches_other;
        logic            other_reaches_new;
        logic            overflow;
    } result_t;

endpackage

FILE: hdl/aprns_mul_unit.sv
module aprns_mul_unit (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [aprns_pkg::MUL_W-1:0]  op_a,
    input  logic [aprns_pkg::MUL_W-1:0]  op_b,
    output logic [aprns_pkg::PROD_W-1:0] prod
);
    import aprns_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Registered product; hold while idle so consumers can stall
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hdl/all_pairs_radius_neighbor_search_unit.sv
// Channel   Direction  Handshake          Payload
// s_*       in         s_valid/s_ready    start_set, point_size, pos_x, pos_y, pos_z
// m_*       out        m_valid/m_ready    point_id, other_id, reach flags, overflow, last
// cfg_*     in         cfg_wr_en          cfg_index, cfg_data (write only, no wait)
//
// A point keeps s_ready low after its transfer while it is compared with each stored
// point and, with the self pair enabled, paired with itself; a dropped point (store
// full) keeps it low until its overflow result enters the output register. Each stored
// point takes the store read, five passes through the shared 33x33 multiplier (three
// squares, radius product, radius square) and the compare. Reset (aresetn low,
// synchronous) empties the set and loads register defaults. A stalled m_ready holds the
// sequencer only when a result must enter the output register while that register is full and not taken.
module all_pairs_radius_neighbor_search_unit #(
    parameter int MAX_POINTS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [aprns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aprns_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_set,
    input  logic [aprns_pkg::SIZE_W-1:0]        s_point_size,
    input  logic signed [aprns_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [aprns_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [aprns_pkg::COORD_W-1:0] s_pos_z,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [aprns_pkg::ID_W-1:0]          m_point_id,
    output logic [aprns_pkg::ID_W-1:0]          m_other_id,
    output logic                                m_new_reaches_other,
    output logic                                m_other_reaches_new,
    output logic                                m_overflow,
    output logic                                m_last
);
    import aprns_pkg::*;

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int WORD_W = SIZE_W + 3 * COORD_W;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_OVF  = 4'd1;
    localparam logic [3:0] ST_SZG  = 4'd2;   // own size times gain
    localparam logic [3:0] ST_BNSQ = 4'd3;   // square of own radius
    localparam logic [3:0] ST_HOLD = 4'd4;   // keep own radius squared
    localparam logic [3:0] ST_CHK  = 4'd5;   // loop test, issue store read
    localparam logic [3:0] ST_SQX  = 4'd6;
    localparam logic [3:0] ST_SQY  = 4'd7;
    localparam logic [3:0] ST_SQZ  = 4'd8;
    localparam logic [3:0] ST_BO   = 4'd9;   // other (or mean) radius
    localparam logic [3:0] ST_BOSQ = 4'd10;
    localparam logic [3:0] ST_CMP  = 4'd11;
    localparam logic [3:0] ST_SELF = 4'd12;
    localparam logic [3:0] ST_FIN  = 4'd13;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    // Configuration registers
    logic              radius_mode_reg;
    logic [GAIN_W-1:0] radius_gain_reg;
    logic              include_self_reg;
    logic              use_three_dims_reg;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] j_reg, j_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state
    logic [SIZE_W-1:0]  sz_reg;
    logic [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [PROD_W-1:0]  bn2_reg;
    logic [D2_W-1:0]    d2_reg, d2_next;
    result_t            pend_res_reg, pend_res_next;
    result_t            out_res_reg, out_res_next;
    logic               out_last_reg, out_last_next;

    // Point store
    logic [WORD_W-1:0] store_mem [MAX_POINTS];
    logic [WORD_W-1:0] rd_word_reg;
    logic              store_wr;

    logic [SIZE_W-1:0]  os;
    logic [COORD_W-1:0] ox, oy, oz;

    // Shared multiplier
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    logic [CMP_W-1:0] lhs;
    logic             nro, orn, hit;
    logic             out_free;
    logic             s_xfer;
    logic [CW-1:0]    me_start;
    result_t          self_res, hit_res, ovf_res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign me_start = s_start_set ? '0 : count_reg;

    assign {os, oz, oy, ox} = rd_word_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_mode_reg    <= 1'b0;
            radius_gain_reg    <= GAIN_RESET;
            include_self_reg   <= 1'b0;
            use_three_dims_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RADIUS_MODE:    radius_mode_reg    <= cfg_data[0];
                REG_RADIUS_GAIN:    radius_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_INCLUDE_SELF:   include_self_reg   <= cfg_data[0];
                REG_USE_THREE_DIMS: use_three_dims_reg <= cfg_data[0];
            endcase
        end
    end

    // Multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SZG: begin
                mul_a = MUL_W'(sz_reg);
                mul_b = MUL_W'(radius_gain_reg);
            end
            ST_BNSQ, ST_BOSQ: begin
                mul_a = prod[MUL_W-1:0];
                mul_b = prod[MUL_W-1:0];
            end
            ST_SQX: begin
                mul_a = MUL_W'(abs_diff(px_reg, ox));
                mul_b = mul_a;
            end
            ST_SQY: begin
                mul_a = MUL_W'(abs_diff(py_reg, oy));
                mul_b = mul_a;
            end
            ST_SQZ: begin
                mul_a = MUL_W'(abs_diff(pz_reg, oz));
                mul_b = mul_a;
            end
            ST_BO: begin
                mul_a = radius_mode_reg ? MUL_W'(sz_reg) + MUL_W'(os) : MUL_W'(os);
                mul_b = MUL_W'(radius_gain_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    aprns_mul_unit u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Strict test: d2 scaled to radius units below radius squared
    assign lhs = radius_mode_reg ? (CMP_W'(d2_reg) << SH_MEAN) : (CMP_W'(d2_reg) << SH_OWN);
    assign orn = lhs < CMP_W'(prod);
    assign nro = radius_mode_reg ? orn : (lhs < CMP_W'(bn2_reg));
    assign hit = nro || orn;

    always_comb begin
        hit_res.point_id          = ID_W'(count_reg);
        hit_res.other_id          = ID_W'(j_reg);
        hit_res.new_reaches_other = nro;
        hit_res.other_reaches_new = orn;
        hit_res.overflow          = 1'b0;

        self_res.point_id          = ID_W'(count_reg);
        self_res.other_id          = ID_W'(count_reg);
        self_res.new_reaches_other = 1'b1;
        self_res.other_reaches_new = 1'b1;
        self_res.overflow          = 1'b0;

        ovf_res          = '0;
        ovf_res.overflow = 1'b1;
    end

    // Sequencer. One result waits in pend so the final one can carry last.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        j_next          = j_reg;
        d2_next         = d2_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        store_wr        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    count_next = me_start;
                    j_next     = '0;
                    if (me_start >= CW'(MAX_POINTS)) begin
                        state_next = ST_OVF;
                    end else begin
                        state_next = ST_SZG;
                    end
                end
            end
            ST_OVF: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = ovf_res;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SZG:  state_next = ST_BNSQ;
            ST_BNSQ: state_next = ST_HOLD;
            ST_HOLD: state_next = ST_CHK;
            ST_CHK: begin
                if (j_reg == count_reg) begin
                    state_next = include_self_reg ? ST_SELF : ST_FIN;
                end else begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX: state_next = ST_SQY;
            ST_SQY: begin
                d2_next    = D2_W'(prod[SQ_W-1:0]);
                state_next = ST_SQZ;
            end
            ST_SQZ: begin
                d2_next    = d2_reg + D2_W'(prod[SQ_W-1:0]);
                state_next = ST_BO;
            end
            ST_BO: begin
                if (use_three_dims_reg) begin
                    d2_next = d2_reg + D2_W'(prod[SQ_W-1:0]);
                end
                state_next = ST_BOSQ;
            end
            ST_BOSQ: state_next = ST_CMP;
            ST_CMP: begin
                if (!hit) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CHK;
                end else if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_res_next   = pend_res_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_res_next   = hit_res;
                    j_next          = j_reg + 1'b1;
                    state_next      = ST_CHK;
                end
            end
            ST_SELF: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_res_next   = pend_res_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_res_next   = self_res;
                    state_next      = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next  = 1'b1;
                        out_res_next    = pend_res_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    store_wr   = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sz_reg <= s_point_size;
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
            pz_reg <= s_pos_z;
        end
        if (state_reg == ST_HOLD) begin
            bn2_reg <= prod;
        end
        d2_reg       <= d2_next;
        pend_res_reg <= pend_res_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

    // Point store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[count_reg[AW-1:0]] <= {sz_reg, pz_reg, py_reg, px_reg};
        end
        rd_word_reg <= store_mem[j_reg[AW-1:0]];
    end

    assign m_valid             = out_valid_reg;
    assign m_point_id          = out_res_reg.point_id;
    assign m_other_id          = out_res_reg.other_id;
    assign m_new_reaches_other = out_res_reg.new_reaches_other;
    assign m_other_reaches_new = out_res_reg.other_reaches_new;
    assign m_overflow          = out_res_reg.overflow;
    assign m_last              = out_last_reg;

`ifndef NO_ASSERTIONS
    // A new point never starts while a result of the previous one is parked
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending result left behind at idle");

    // An overflow result is always the only, hence last, result
    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> m_last)
        else $error("overflow result without last");

    // Set size never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    // Loop index stays within the stored part of the set
    a_j_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (j_reg <= count_reg))
        else $error("loop index past stored points");
`endif

endmodule
